// ----- design/jpgs_pkg.sv -----
// ----------------------------------------------------------------------------
// jpgs_pkg
// Shared types and constants of the Jacobi five-point Poisson grid solver:
// transaction payloads, register indexes, controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package jpgs_pkg;

   // Request actions
   typedef enum logic [1:0] {
      ACTION_LOAD  = 2'd0,
      ACTION_SOLVE = 2'd1,
      ACTION_READ  = 2'd2
   } action_type;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_SIZE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MESH_STEP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ITER   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE  = 2'd3;

   // Register reset values
   localparam logic [6:0]  GRID_SIZE_RESET = 7'd64;
   localparam logic [15:0] MESH_STEP_RESET = 16'd1040;
   localparam logic [15:0] MAX_ITER_RESET  = 16'd1000;
   localparam logic [30:0] TOLERANCE_RESET = 31'd66;

   // Largest reportable error norm
   localparam logic [30:0] ERROR_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      action_type         action;
      logic [11:0]        point_index;
      logic signed [31:0] start_value;
      logic signed [31:0] rhs_value;
      logic signed [31:0] exact_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_value;
      logic [15:0]        iterations;
      logic               converged;
      logic [30:0]        final_error;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_COPY,
      ST_LOOP,
      ST_SWEEP,
      ST_NORM,
      ST_SQRT,
      ST_ERR,
      ST_ESQRT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load_write;
      logic read_issue;
      logic res_clear;
      logic res_point;
      logic res_solve;
      logic solve_setup;
      logic pass_start;
      logic pass_exact;
      logic sweep_start;
      logic sqrt_start;
      logic iter_inc;
      logic conv_mark;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic pass_busy;
      logic sweep_busy;
      logic sqrt_busy;
      logic limit_hit;
      logic below_tol;
   } dp_status_type;

endpackage

// ----- design/jpgs_ctrl.sv -----
// ----------------------------------------------------------------------------
// jpgs_ctrl
// Controller of the grid solver: sequences load, read and solve
// transactions and owns the result valid flag.
// ----------------------------------------------------------------------------
module jpgs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  jpgs_pkg::action_type    req_action,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  jpgs_pkg::dp_status_type sts,
   output jpgs_pkg::ctl_cmd_type   cmd
);

   jpgs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == jpgs_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         jpgs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  jpgs_pkg::ACTION_SOLVE: state_in = jpgs_pkg::ST_COPY;
                  jpgs_pkg::ACTION_READ:  state_in = jpgs_pkg::ST_READ;
                  default:                state_in = jpgs_pkg::ST_RESP;
               endcase
            end
         end
         jpgs_pkg::ST_READ:  state_in = jpgs_pkg::ST_RESP;
         jpgs_pkg::ST_COPY: begin
            if (!sts.pass_busy) state_in = jpgs_pkg::ST_LOOP;
         end
         jpgs_pkg::ST_LOOP: begin
            state_in = sts.limit_hit ? jpgs_pkg::ST_ERR : jpgs_pkg::ST_SWEEP;
         end
         jpgs_pkg::ST_SWEEP: begin
            if (!sts.sweep_busy) state_in = jpgs_pkg::ST_NORM;
         end
         jpgs_pkg::ST_NORM: begin
            if (!sts.pass_busy) state_in = jpgs_pkg::ST_SQRT;
         end
         jpgs_pkg::ST_SQRT: begin
            if (!sts.sqrt_busy) begin
               state_in = sts.below_tol ? jpgs_pkg::ST_ERR : jpgs_pkg::ST_LOOP;
            end
         end
         jpgs_pkg::ST_ERR: begin
            if (!sts.pass_busy) state_in = jpgs_pkg::ST_ESQRT;
         end
         jpgs_pkg::ST_ESQRT: begin
            if (!sts.sqrt_busy) state_in = jpgs_pkg::ST_RESP;
         end
         jpgs_pkg::ST_RESP: begin
            if (out_free) state_in = jpgs_pkg::ST_IDLE;
         end
         default: state_in = jpgs_pkg::ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         jpgs_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  jpgs_pkg::ACTION_LOAD: begin
                     cmd.load_write = 1'b1;
                     cmd.res_clear  = 1'b1;
                  end
                  jpgs_pkg::ACTION_SOLVE: begin
                     cmd.solve_setup = 1'b1;
                     cmd.pass_start  = 1'b1;
                  end
                  jpgs_pkg::ACTION_READ: cmd.read_issue = 1'b1;
                  default:               cmd.res_clear  = 1'b1;
               endcase
            end
         end
         jpgs_pkg::ST_READ: cmd.res_point = 1'b1;
         jpgs_pkg::ST_COPY: ;
         jpgs_pkg::ST_LOOP: begin
            if (sts.limit_hit) begin
               cmd.pass_start = 1'b1;
               cmd.pass_exact = 1'b1;
            end else begin
               cmd.sweep_start = 1'b1;
            end
         end
         jpgs_pkg::ST_SWEEP: cmd.pass_start = !sts.sweep_busy;
         jpgs_pkg::ST_NORM:  cmd.sqrt_start = !sts.pass_busy;
         jpgs_pkg::ST_SQRT: begin
            if (!sts.sqrt_busy) begin
               if (sts.below_tol) begin
                  cmd.conv_mark  = 1'b1;
                  cmd.pass_start = 1'b1;
                  cmd.pass_exact = 1'b1;
               end else begin
                  cmd.iter_inc = 1'b1;
               end
            end
         end
         jpgs_pkg::ST_ERR:   cmd.sqrt_start = !sts.pass_busy;
         jpgs_pkg::ST_ESQRT: cmd.res_solve  = !sts.sqrt_busy;
         jpgs_pkg::ST_RESP:  cmd.out_load   = out_free;
         default: ;
      endcase
   end

   // Hold the result valid until the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jpgs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- design/jpgs_datapath.sv -----
// ----------------------------------------------------------------------------
// jpgs_datapath
// Grid memories, configuration registers, stencil sequencer, norm pass
// pipeline, bit-serial square root and result registers.
// ----------------------------------------------------------------------------
module jpgs_datapath #(
   parameter int GRID_MAX = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  jpgs_pkg::req_type                   req_data,
   output jpgs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [jpgs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                         csr_data,
   input  jpgs_pkg::ctl_cmd_type               cmd,
   output jpgs_pkg::dp_status_type             sts
);

   localparam int CELLS  = GRID_MAX * GRID_MAX;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int N_W    = $clog2(GRID_MAX + 1);
   localparam logic [2:0] PH_LAST = 3'd5;

   // Memories
   logic signed [31:0] sol_mem   [CELLS];
   logic signed [31:0] prev_mem  [CELLS];
   logic signed [31:0] rhs_mem   [CELLS];
   logic signed [31:0] exact_mem [CELLS];
   logic signed [31:0] sol_q, prev_q, rhs_q, exact_q;
   logic [ADDR_W-1:0]  sol_raddr, prev_raddr;

   // Configuration
   logic [6:0]  grid_size_ff;
   logic [15:0] mesh_step_ff, max_iter_ff;
   logic [30:0] tolerance_ff;

   // Solve setup
   logic [N_W-1:0]   n_cfg, n_ff;
   logic [CNT_W-1:0] cells_ff;
   logic [31:0]      h2_ff;
   logic [15:0]      iter_ff;
   logic             conv_ff;

   // Load and read
   logic              load_ok, rd_ok_ff;
   logic [ADDR_W-1:0] req_addr;

   // Norm pass
   logic              pass_active_ff, pass_exact_ff, v1_ff, v2_ff, issue;
   logic [CNT_W-1:0]  k_ff;
   logic [ADDR_W-1:0] kd_ff;
   logic signed [32:0] diff;
   logic [31:0]        mag;
   logic [63:0]        sq_ff, sum_ff;
   logic [64:0]        sum_wide;

   // Stencil sequencer
   logic              sw_active_ff;
   logic [2:0]        ph_ff;
   logic [ADDR_W-1:0] c_ff, n_addr, sw_addr;
   logic [N_W-1:0]    i_ff, j_ff, n_inner;
   logic signed [35:0] acc_ff, term, s_sum, r_q;
   logic signed [65:0] prod_ff, prod_rnd;
   logic signed [32:0] h2_s, rhs_s;
   logic signed [31:0] new_val;
   logic               sw_write;

   // Square root
   logic [63:0] rem_ff, root_ff, bit_ff, trial, scaled, hi_prod;
   logic [31:0] lo_prod;
   logic [64:0] scaled_wide;

   // Results
   jpgs_pkg::rsp_type res_ff, rsp_ff;

   assign rsp_data = rsp_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_size_ff <= jpgs_pkg::GRID_SIZE_RESET;
         mesh_step_ff <= jpgs_pkg::MESH_STEP_RESET;
         max_iter_ff  <= jpgs_pkg::MAX_ITER_RESET;
         tolerance_ff <= jpgs_pkg::TOLERANCE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            jpgs_pkg::CSR_GRID_SIZE: grid_size_ff <= csr_data[6:0];
            jpgs_pkg::CSR_MESH_STEP: mesh_step_ff <= csr_data[15:0];
            jpgs_pkg::CSR_MAX_ITER:  max_iter_ff  <= csr_data[15:0];
            jpgs_pkg::CSR_TOLERANCE: tolerance_ff <= csr_data[30:0];
         endcase
      end
   end

   // Clamp the grid to the store size
   assign n_cfg = (32'(grid_size_ff) > 32'(GRID_MAX)) ? N_W'(GRID_MAX) : N_W'(grid_size_ff);
   assign load_ok  = 32'(req_data.point_index) < 32'(CELLS);
   assign req_addr = ADDR_W'(req_data.point_index);

   // Solve setup and iteration count
   always_ff @(posedge clock) begin
      if (cmd.solve_setup) begin
         n_ff     <= n_cfg;
         cells_ff <= CNT_W'(CNT_W'(n_cfg) * CNT_W'(n_cfg));
         h2_ff    <= 32'(mesh_step_ff) * 32'(mesh_step_ff);
         iter_ff  <= '0;
         conv_ff  <= 1'b0;
      end else begin
         if (cmd.iter_inc)  iter_ff <= iter_ff + 16'd1;
         if (cmd.conv_mark) conv_ff <= 1'b1;
      end
      if (cmd.read_issue) rd_ok_ff <= load_ok;
   end

   // Norm pass: read both stores, square the change, accumulate
   assign issue = pass_active_ff && (k_ff < cells_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_active_ff <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         if (cmd.pass_start) begin
            pass_active_ff <= 1'b1;
         end else if (pass_active_ff && !issue && !v1_ff && !v2_ff) begin
            pass_active_ff <= 1'b0;
         end
      end
   end

   assign diff     = 33'(sol_q) - 33'(pass_exact_ff ? exact_q : prev_q);
   assign mag      = diff[32] ? 32'(-diff) : 32'(diff);
   assign sum_wide = {1'b0, sum_ff} + {1'b0, sq_ff};

   always_ff @(posedge clock) begin
      if (cmd.pass_start) begin
         k_ff          <= '0;
         sum_ff        <= '0;
         pass_exact_ff <= cmd.pass_exact;
      end else begin
         if (issue) k_ff <= k_ff + CNT_W'(1);
         if (v2_ff) sum_ff <= sum_wide[64] ? '1 : sum_wide[63:0];
      end
      kd_ff <= k_ff[ADDR_W-1:0];
      sq_ff <= 64'(mag) * 64'(mag);
   end

   // Stencil sequencer over the interior, six phases per point
   assign n_addr  = ADDR_W'(n_ff);
   assign n_inner = n_ff - N_W'(2);

   always_comb begin
      unique case (ph_ff)
         3'd0:    sw_addr = c_ff - n_addr;
         3'd1:    sw_addr = c_ff + n_addr;
         3'd2:    sw_addr = c_ff - ADDR_W'(1);
         default: sw_addr = c_ff + ADDR_W'(1);
      endcase
   end

   assign h2_s     = {1'b0, h2_ff};
   assign rhs_s    = {rhs_q[31], rhs_q};
   assign prod_rnd = prod_ff + 66'sd2147483648;
   assign term     = 36'(prod_rnd >>> 32);
   assign s_sum    = acc_ff + term + 36'sd2;
   assign r_q      = s_sum >>> 2;
   assign sw_write = sw_active_ff && (ph_ff == PH_LAST);

   // Saturate the new point to 32 bits
   always_comb begin
      if (r_q > 36'sd2147483647) begin
         new_val = 32'sh7FFF_FFFF;
      end else if (r_q < -36'sd2147483648) begin
         new_val = 32'sh8000_0000;
      end else begin
         new_val = 32'(r_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_active_ff <= 1'b0;
      end else if (cmd.sweep_start) begin
         sw_active_ff <= (n_ff >= N_W'(3));
      end else if (sw_write && (j_ff == n_inner) && (i_ff == n_inner)) begin
         sw_active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep_start) begin
         c_ff  <= n_addr + ADDR_W'(1);
         i_ff  <= N_W'(1);
         j_ff  <= N_W'(1);
         ph_ff <= '0;
      end else if (sw_active_ff) begin
         ph_ff <= (ph_ff == PH_LAST) ? 3'd0 : ph_ff + 3'd1;
         if (sw_write) begin
            if (j_ff == n_inner) begin
               i_ff <= i_ff + N_W'(1);
               j_ff <= N_W'(1);
               c_ff <= c_ff + ADDR_W'(3);
            end else begin
               j_ff <= j_ff + N_W'(1);
               c_ff <= c_ff + ADDR_W'(1);
            end
         end
      end
      // Gather the four neighbors and the scaled source term
      unique case (ph_ff)
         3'd1:       acc_ff <= 36'(prev_q);
         3'd2, 3'd3,
         3'd4:       acc_ff <= acc_ff + 36'(prev_q);
         default: ;
      endcase
      if (ph_ff == 3'd1) prod_ff <= h2_s * rhs_s;
   end

   // Memory ports
   assign sol_raddr  = pass_active_ff ? k_ff[ADDR_W-1:0] : req_addr;
   assign prev_raddr = sw_active_ff ? sw_addr : k_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load_write && load_ok) begin
         sol_mem[req_addr]   <= req_data.start_value;
         rhs_mem[req_addr]   <= req_data.rhs_value;
         exact_mem[req_addr] <= req_data.exact_value;
      end else if (sw_write) begin
         sol_mem[c_ff] <= new_val;
      end
      if (v1_ff && !pass_exact_ff) prev_mem[kd_ff] <= sol_q;
      sol_q   <= sol_mem[sol_raddr];
      prev_q  <= prev_mem[prev_raddr];
      rhs_q   <= rhs_mem[c_ff];
      exact_q <= exact_mem[k_ff[ADDR_W-1:0]];
   end

   // Scale the sum by h, truncated to Q32.32 and saturated
   assign hi_prod     = 64'(sum_ff[63:16]) * 64'(mesh_step_ff);
   assign lo_prod     = 32'(sum_ff[15:0]) * 32'(mesh_step_ff);
   assign scaled_wide = {1'b0, hi_prod} + 65'(lo_prod[31:16]);
   assign scaled      = scaled_wide[64] ? '1 : scaled_wide[63:0];

   // Bit-serial floor square root, one result bit per cycle
   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (cmd.sqrt_start) begin
         bit_ff <= 64'd1 << 62;
      end else if (bit_ff != '0) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rem_ff  <= scaled;
         root_ff <= '0;
      end else if (bit_ff != '0) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   assign sts.pass_busy  = pass_active_ff;
   assign sts.sweep_busy = sw_active_ff;
   assign sts.sqrt_busy  = (bit_ff != '0);
   assign sts.limit_hit  = (iter_ff == max_iter_ff);
   assign sts.below_tol  = root_ff < 64'(tolerance_ff);

   // Result assembly and output register
   always_ff @(posedge clock) begin
      if (cmd.res_clear) begin
         res_ff <= '0;
      end else if (cmd.res_point) begin
         res_ff.point_value <= rd_ok_ff ? sol_q : 32'sd0;
         res_ff.iterations  <= '0;
         res_ff.converged   <= 1'b0;
         res_ff.final_error <= '0;
      end else if (cmd.res_solve) begin
         res_ff.point_value <= '0;
         res_ff.iterations  <= iter_ff;
         res_ff.converged   <= conv_ff;
         res_ff.final_error <= (root_ff > 64'(jpgs_pkg::ERROR_MAX)) ?
                               jpgs_pkg::ERROR_MAX : root_ff[30:0];
      end
      if (cmd.out_load) rsp_ff <= res_ff;
   end

endmodule

// ----- design/jacobi_poisson_grid_solver_unit.sv -----
// ----------------------------------------------------------------------------
// jacobi_poisson_grid_solver_unit
// Jacobi solver for the five-point Poisson stencil on a square grid.
// ----------------------------------------------------------------------------
// Usage: req_ carries one transaction per action. A load writes start value,
// right-hand side and exact value of one point; a read returns one solution
// point; a solve runs Jacobi sweeps until the change norm drops below the
// tolerance or the sweep limit is hit, then reports the sweep index, the
// converged flag and the error norm. Every transaction yields exactly one
// rsp_ transaction. The csr_ channel writes the four registers, one per cycle.
// A solve runs a first copy pass, then per sweep the stencil work (one
// memory read port on the previous grid, four neighbor reads per point),
// the norm pass and the square root, then the error norm pass and its
// square root. One transaction is in flight at a time. The result register
// holds a finished result while the receiver stalls, and req_ready returns
// once the result is registered.
// Reset restores the register defaults and clears the control state; the
// grid stores are not cleared.
// ----------------------------------------------------------------------------
module jacobi_poisson_grid_solver_unit #(
   parameter int GRID_MAX = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  jpgs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output jpgs_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jpgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_data
);

   jpgs_pkg::ctl_cmd_type   cmd;
   jpgs_pkg::dp_status_type sts;

   // Accept register writes in every cycle
   assign csr_ready = 1'b1;

   jpgs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_data.action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   jpgs_datapath #(
      .GRID_MAX (GRID_MAX)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ----- design/jpgs_checker.sv -----
// ----------------------------------------------------------------------------
// jpgs_checker
// Port-level checks of the grid solver, bound to the top level.
// ----------------------------------------------------------------------------
module jpgs_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input jpgs_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready
);

   // Leave reset idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // Stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result dropped or changed while stalled");

   // Take one request transaction at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   // Register port never stalls
   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind jacobi_poisson_grid_solver_unit jpgs_checker u_jpgs_checker (.*);
